### src/bops_pkg.sv
`default_nettype none

package bops_pkg;

    // fixed field widths
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned LEVEL_W  = 16;
    localparam int unsigned PHASE_W  = 32;
    localparam int unsigned HOLD_W   = 19;
    localparam int unsigned REFR_W   = 17;
    localparam int unsigned DT_W     = 17;
    localparam int unsigned RATE_W   = 20;
    localparam int unsigned GAIN_W   = 13;

    // gain divider widths: numerator 13h + 7r, denominator 5h
    localparam int unsigned DIV_NUM_W  = 24;
    localparam int unsigned DIV_DEN_W  = 22;
    // low numerator bits shifted in: 3 bits of the numerator, then 10 zero bits (times 1024)
    localparam int unsigned DIV_LOW_W  = 3;
    localparam int unsigned DIV_STEPS  = GAIN_W;
    localparam int unsigned DIV_CNT_W  = 4;

    // timing constants in microseconds
    localparam logic [REFR_W-1:0] REFRACTORY_US = 17'd120000;
    localparam logic [DT_W-1:0]   DT_MAX_US     = 17'd100000;
    localparam logic [TIME_W-1:0] DT_MIN_US     = 32'd10;
    localparam logic [TIME_W-1:0] DT_NEG_MIN    = 32'hFFFF_FFF7;
    localparam logic [HOLD_W-1:0] HOLD_FLOOR_US = 19'd1000;

    // gain of 1.0 in Q12
    localparam logic [GAIN_W-1:0] GAIN_ONE = 13'd4096;

    // register reset values
    localparam logic [HOLD_W-1:0]  HOLD_TIME_RST = 19'd150000;
    localparam logic [15:0]        THRESH_RST    = 16'd19661;
    localparam logic [RATE_W-1:0]  RATE_RST      = 20'd4295;

    // register map, one word apart
    typedef enum logic [1:0] {
        REG_SNAP_MODE  = 2'd0,
        REG_HOLD_TIME  = 2'd1,
        REG_THRESHOLD  = 2'd2,
        REG_PHASE_RATE = 2'd3
    } bops_reg_t;

    // request to the gain divider
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } bops_div_req_t;

    // status back from the gain divider
    typedef struct packed {
        logic busy;
        logic done;
    } bops_div_stat_t;

endpackage

`default_nettype wire

### src/bops_gain_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
// quotient = floor(num * 1024 / den), known to stay below 2^13
module bops_gain_div (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire bops_pkg::bops_div_req_t        req,
    output bops_pkg::bops_div_stat_t            stat,
    output logic [bops_pkg::GAIN_W-1:0]         quot
);
    import bops_pkg::*;

    localparam int unsigned LOW_TOTAL = DIV_LOW_W + 10;

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [LOW_TOTAL-1:0] low_reg;
    logic [GAIN_W-1:0]    quot_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   trial;
    logic                 take;
    logic [DIV_DEN_W:0]   diff;

    // trial subtract of the next partial remainder
    always_comb begin
        trial = {rem_reg, low_reg[LOW_TOTAL-1]};
        diff  = trial - {1'b0, den_reg};
        take  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                // upper numerator bits start below the divisor
                rem_reg  <= {1'b0, req.num[DIV_NUM_W-1:DIV_LOW_W]};
                low_reg  <= {req.num[DIV_LOW_W-1:0], 10'd0};
                den_reg  <= req.den;
                quot_reg <= '0;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= take ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
                low_reg  <= {low_reg[LOW_TOTAL-2:0], 1'b0};
                quot_reg <= {quot_reg[GAIN_W-2:0], take};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

`default_nettype wire

### src/beat_onset_phase_snap_top.sv
`default_nettype none

// Beat onset phase snap. Each input beat carries a microsecond timestamp and an onset
// level; the block steps a wrapping 32-bit phase by dt * phase_rate, smooths the onset,
// fires a beat past the threshold once the 120 ms refractory time has run out, then holds
// a frozen or half-cycle-shifted phase for hold_time_us. One result beat per input beat.
// The 17-step shift-add multiplier for the phase advance and the 13-step restoring divider
// for the pulse gain run in turn between one input accept and the next. A beat other than
// the first whose time step is under 10 us in either direction skips the multiplier, and
// a result outside a hold skips the divider.
// A new input beat is taken while the previous result still waits at the output register.
module beat_onset_phase_snap_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [31:0] time_us, [47:32] onset_level
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] phase_out, [16] holding_flag,
                                        // [17] beat_fired, [30:18] pulse_gain, [31] zero
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bops_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_MUL,
        ST_UPD,
        ST_GAIN,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam int unsigned MUL_CNT_W = 5;

    state_t state_reg;

    // configuration registers
    logic              snap_mode_reg;
    logic [HOLD_W-1:0] hold_time_reg;
    logic [15:0]       threshold_reg;
    logic [RATE_W-1:0] phase_rate_reg;

    // tracker state
    logic [TIME_W-1:0]  last_time_reg;
    logic               first_tick_reg;
    logic [PHASE_W-1:0] running_phase_reg;
    logic [PHASE_W-1:0] snapped_phase_reg;
    logic [LEVEL_W-1:0] smoothed_reg;
    logic [REFR_W-1:0]  refractory_reg;
    logic [HOLD_W-1:0]  hold_left_reg;
    logic               holding_reg;

    // per-beat working registers
    logic [TIME_W-1:0]  time_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [DT_W-1:0]    dt_reg;
    logic               fired_reg;
    logic [GAIN_W-1:0]  gain_reg;

    // shift-add multiplier
    logic [PHASE_W-1:0]   mul_cand_reg;
    logic [DT_W-1:0]      mul_plier_reg;
    logic [PHASE_W-1:0]   prod_reg;
    logic [MUL_CNT_W-1:0] mul_cnt_reg;

    // output register
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        out_load;

    logic cfg_wr;

    // step decode
    logic [TIME_W-1:0]  d_step;
    logic               tiny_step;
    logic [DT_W-1:0]    dt_step;
    logic [LEVEL_W:0]   level_sum;

    // update decode
    logic [PHASE_W-1:0] phase_next;
    logic [REFR_W-1:0]  refr_dec;
    logic               fire;
    logic [HOLD_W-1:0]  hold_base;
    logic               hold_active;
    logic [HOLD_W-1:0]  hold_next;

    // gain operands
    logic [HOLD_W-1:0]    gain_h;
    logic [HOLD_W-1:0]    gain_r;
    logic [DIV_NUM_W-1:0] h_num;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] h_den;

    bops_div_req_t  div_req;
    bops_div_stat_t div_stat;
    logic [GAIN_W-1:0] div_quot;

    // register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (bops_reg_t'(paddr[3:2]))
            REG_SNAP_MODE:  prdata = {31'd0, snap_mode_reg};
            REG_HOLD_TIME:  prdata = {13'd0, hold_time_reg};
            REG_THRESHOLD:  prdata = {16'd0, threshold_reg};
            REG_PHASE_RATE: prdata = {12'd0, phase_rate_reg};
            default:        prdata = '0;
        endcase
    end

    // time step, clamped, with the tiny-step test
    always_comb begin
        d_step    = time_reg - last_time_reg;
        tiny_step = !first_tick_reg && (d_step < DT_MIN_US || d_step >= DT_NEG_MIN);
        if (first_tick_reg || d_step[TIME_W-1]) begin
            dt_step = '0;
        end else if (d_step > {15'd0, DT_MAX_US}) begin
            dt_step = DT_MAX_US;
        end else begin
            dt_step = d_step[DT_W-1:0];
        end
        level_sum = {1'b0, smoothed_reg} + {1'b0, level_reg};
    end

    // phase, refractory, beat and hold for this beat
    always_comb begin
        phase_next  = running_phase_reg + prod_reg;
        refr_dec    = (refractory_reg > dt_reg) ? refractory_reg - dt_reg : '0;
        fire        = (refr_dec == '0) && (smoothed_reg >= threshold_reg);
        hold_base   = fire ? hold_time_reg : hold_left_reg;
        hold_active = fire || holding_reg;
        hold_next   = (hold_base > {2'd0, dt_reg}) ? hold_base - {2'd0, dt_reg} : '0;
    end

    // gain = 1024 * (13h + 7r) / (5h)
    always_comb begin
        gain_h = (hold_time_reg < HOLD_FLOOR_US) ? HOLD_FLOOR_US : hold_time_reg;
        gain_r = (hold_left_reg < gain_h) ? hold_left_reg : gain_h;
        h_num  = {5'd0, gain_h};
        r_num  = {5'd0, gain_r};
        h_den  = {3'd0, gain_h};
        div_req.start = (state_reg == ST_GAIN) && holding_reg;
        div_req.num   = (h_num << 3) + (h_num << 2) + h_num + (r_num << 3) - r_num;
        div_req.den   = (h_den << 2) + h_den;
    end

    bops_gain_div u_gain_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    // result goes out once the output register is free or being emptied
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // sequencer and all registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            snap_mode_reg     <= 1'b0;
            hold_time_reg     <= HOLD_TIME_RST;
            threshold_reg     <= THRESH_RST;
            phase_rate_reg    <= RATE_RST;
            last_time_reg     <= '0;
            first_tick_reg    <= 1'b1;
            running_phase_reg <= '0;
            snapped_phase_reg <= '0;
            smoothed_reg      <= '0;
            refractory_reg    <= '0;
            hold_left_reg     <= '0;
            holding_reg       <= 1'b0;
            fired_reg         <= 1'b0;
            mul_cnt_reg       <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (bops_reg_t'(paddr[3:2]))
                    REG_SNAP_MODE:  snap_mode_reg  <= pwdata[0];
                    REG_HOLD_TIME:  hold_time_reg  <= pwdata[HOLD_W-1:0];
                    REG_THRESHOLD:  threshold_reg  <= pwdata[15:0];
                    REG_PHASE_RATE: phase_rate_reg <= pwdata[RATE_W-1:0];
                    default:        ;
                endcase
            end

            // output valid: load a new beat or retire the accepted one
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        time_reg  <= s_tdata[31:0];
                        level_reg <= s_tdata[47:32];
                        fired_reg <= 1'b0;
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    if (tiny_step) begin
                        state_reg <= ST_GAIN;
                    end else begin
                        first_tick_reg <= 1'b0;
                        last_time_reg  <= time_reg;
                        smoothed_reg   <= level_sum[LEVEL_W:1];
                        dt_reg         <= dt_step;
                        mul_cand_reg   <= {12'd0, phase_rate_reg};
                        mul_plier_reg  <= dt_step;
                        prod_reg       <= '0;
                        mul_cnt_reg    <= MUL_CNT_W'(DT_W);
                        state_reg      <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // one multiplier bit of dt per cycle
                    if (mul_plier_reg[0]) begin
                        prod_reg <= prod_reg + mul_cand_reg;
                    end
                    mul_cand_reg  <= {mul_cand_reg[PHASE_W-2:0], 1'b0};
                    mul_plier_reg <= {1'b0, mul_plier_reg[DT_W-1:1]};
                    mul_cnt_reg   <= mul_cnt_reg - 1'b1;
                    if (mul_cnt_reg == MUL_CNT_W'(1)) begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    running_phase_reg <= phase_next;
                    refractory_reg    <= fire ? REFRACTORY_US : refr_dec;
                    fired_reg         <= fire;
                    if (fire) begin
                        snapped_phase_reg <= snap_mode_reg ?
                            {~phase_next[PHASE_W-1], phase_next[PHASE_W-2:0]} : phase_next;
                    end
                    if (hold_active) begin
                        hold_left_reg <= hold_next;
                        holding_reg   <= (hold_next != '0);
                    end
                    state_reg <= ST_GAIN;
                end
                ST_GAIN: begin
                    if (holding_reg) begin
                        state_reg <= ST_DIV;
                    end else begin
                        gain_reg  <= GAIN_ONE;
                        state_reg <= ST_OUT;
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        gain_reg  <= div_quot;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_tdata_reg  <= {1'b0, gain_reg, fired_reg, holding_reg,
                                         holding_reg ? snapped_phase_reg[PHASE_W-1:16]
                                                     : running_phase_reg[PHASE_W-1:16]};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // a hold never sits at zero time left
    a_hold_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        holding_reg |-> (hold_left_reg != '0))
        else $error("holding with no hold time left");

    // refractory timer never exceeds its load value
    a_refr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        refractory_reg <= REFRACTORY_US)
        else $error("refractory timer out of range");

    // gain is 1.0 outside a hold and within range inside one
    a_gain_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[16]) |-> (m_tdata[30:18] == GAIN_ONE))
        else $error("gain not unity outside a hold");

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[30:18] >= 13'd2662 && m_tdata[30:18] <= GAIN_ONE))
        else $error("gain out of range");

    // one beat in flight: no new input right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a beat is in flight");

    // divider only runs while the sequencer waits for it
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside its wait state");
`endif

endmodule

`default_nettype wire
